// ===== rtl/core/mbs_pkg.sv =====
// Shared constants and controller/datapath interface types for the mesh
// bounding sphere core. No dependencies.
`timescale 1ns / 1ps

package mbs_pkg;

    // Default store depth and coordinate width
    localparam int MAX_VERTICES_DEF = 1024;
    localparam int COORD_BITS_DEF   = 16;

    // Number of coordinate axes
    localparam int AXES = 3;

    // Commands from controller to datapath
    typedef struct packed {
        logic store;       // input transfer: store vertex, update box
        logic pass_start;  // begin distance pass over stored vertices
        logic root_start;  // begin square root of the largest distance
        logic publish;     // load result registers and clear mesh state
    } mbs_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic pass_busy;   // distance pass or its pipeline still running
        logic root_busy;   // square root unit iterating
    } mbs_sts_t;

endpackage

// ===== rtl/core/mesh_bounding_sphere_core.sv =====
// Top level of the mesh bounding sphere core: controller plus datapath.
// Uses mbs_pkg, mbs_ctrl, mbs_dpath.
`timescale 1ns / 1ps

// Vertices stream in at one per cycle and are kept in an on-chip store of
// MAX_VERTICES entries while the per-axis box is tracked; vertices beyond the
// store depth are dropped and reported through overflowed. The transfer that
// carries last_vertex starts the distance pass: every stored vertex is read
// back once from the single store port, one per cycle, through a five-stage
// pipeline, after which a bit-serial square root runs on the largest distance.
// The input is stalled from the last vertex until the result is handed to
// the output register. Outputs are twice the box center, an exact integer,
// and twice the sphere radius, rounded down to an integer. No clearing pass
// after reset.
module mesh_bounding_sphere_core #(
    parameter int MAX_VERTICES = mbs_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = mbs_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] pos_x,
    input  logic signed [COORD_BITS-1:0] pos_y,
    input  logic signed [COORD_BITS-1:0] pos_z,
    input  logic                         last_vertex,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [COORD_BITS:0]   center2_x,
    output logic signed [COORD_BITS:0]   center2_y,
    output logic signed [COORD_BITS:0]   center2_z,
    output logic [COORD_BITS+1:0]        radius2,
    output logic                         overflowed
);

    mbs_pkg::mbs_cmd_t cmd;
    mbs_pkg::mbs_sts_t sts;

    mbs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .last_vertex (last_vertex),
        .in_stall    (in_stall),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cmd         (cmd),
        .sts         (sts)
    );

    mbs_dpath #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .center2_x  (center2_x),
        .center2_y  (center2_y),
        .center2_z  (center2_z),
        .radius2    (radius2),
        .overflowed (overflowed)
    );

endmodule

// ===== rtl/core/mbs_isqrt.sv =====
// Iterative floor integer square root, one result bit per cycle.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module mbs_isqrt #(
    parameter int DW = 36
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DW-1:0]     radicand,
    output logic              busy,
    output logic [DW/2-1:0]   root
);

    localparam int RW   = DW / 2;
    localparam int REMW = RW + 2;
    localparam int SW   = $clog2(RW + 1);

    logic [SW-1:0]   step_reg;
    logic [SW-1:0]   step_next;
    logic [DW-1:0]   rad_reg;
    logic [DW-1:0]   rad_next;
    logic [REMW-1:0] rem_reg;
    logic [REMW-1:0] rem_next;
    logic [RW-1:0]   root_reg;
    logic [RW-1:0]   root_next;
    logic [REMW-1:0] trial;
    logic [REMW-1:0] test;

    // Bring down two radicand bits and try the next root bit
    assign trial = {rem_reg[REMW-3:0], rad_reg[DW-1:DW-2]};
    assign test  = {root_reg, 2'b01};

    always_comb
    begin
        step_next = step_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            step_next = SW'(RW);
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (step_reg != '0)
        begin
            step_next = step_reg - SW'(1);
            rad_next  = {rad_reg[DW-3:0], 2'b00};
            if (trial >= test)
            begin
                rem_next  = trial - test;
                root_next = {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                root_next = {root_reg[RW-2:0], 1'b0};
            end
        end
    end

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else
            step_reg <= step_next;
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = (step_reg != '0);
    assign root = root_reg;

endmodule

// ===== rtl/core/mbs_dpath.sv =====
// Datapath of the mesh bounding sphere core: vertex store, box tracking,
// distance pipeline, square root and result registers. Uses mbs_pkg, mbs_isqrt.
`timescale 1ns / 1ps

module mbs_dpath #(
    parameter int MAX_VERTICES = mbs_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = mbs_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mbs_pkg::mbs_cmd_t            cmd,
    output mbs_pkg::mbs_sts_t            sts,
    input  logic signed [COORD_BITS-1:0] pos_x,
    input  logic signed [COORD_BITS-1:0] pos_y,
    input  logic signed [COORD_BITS-1:0] pos_z,
    output logic signed [COORD_BITS:0]   center2_x,
    output logic signed [COORD_BITS:0]   center2_y,
    output logic signed [COORD_BITS:0]   center2_z,
    output logic [COORD_BITS+1:0]        radius2,
    output logic                         overflowed
);

    localparam int CW   = COORD_BITS;
    localparam int NA   = mbs_pkg::AXES;
    localparam int AW   = $clog2(MAX_VERTICES);
    localparam int CNTW = $clog2(MAX_VERTICES + 1);
    localparam int OW   = CW + 2;
    localparam int DW   = (2 * OW > 64) ? 64 : 2 * OW;
    localparam int RW   = DW / 2;

    logic [NA*CW-1:0]       store_mem [MAX_VERTICES];
    logic [NA*CW-1:0]       rd_data_reg;
    logic signed [CW-1:0]   pos [NA];
    logic signed [CW-1:0]   min_reg [NA];
    logic signed [CW-1:0]   max_reg [NA];
    logic signed [CW:0]     c2_reg [NA];
    logic signed [OW-1:0]   off_reg [NA];
    logic [DW-1:0]          sq_reg [NA];
    logic [DW-1:0]          sum_reg;
    logic [DW-1:0]          best_reg;
    logic [CNTW-1:0]        count_reg;
    logic [CNTW-1:0]        rd_idx_reg;
    logic                   drop_reg;
    logic                   full;
    logic                   pass_run_reg;
    logic                   s1_vld_reg;
    logic                   s2_vld_reg;
    logic                   s3_vld_reg;
    logic                   s4_vld_reg;
    logic                   root_busy;
    logic [RW-1:0]          root;
    logic signed [CW:0]     cx_reg;
    logic signed [CW:0]     cy_reg;
    logic signed [CW:0]     cz_reg;
    logic [CW+1:0]          radius_reg;
    logic                   ovf_reg;

    assign pos[0] = pos_x;
    assign pos[1] = pos_y;
    assign pos[2] = pos_z;
    assign full   = (count_reg == CNTW'(MAX_VERTICES));

    // Store vertex while room remains
    always_ff @(posedge clk)
    begin
        if (cmd.store && !full)
            store_mem[count_reg[AW-1:0]] <= {pos_z, pos_y, pos_x};
    end

    // Read stored vertices during the distance pass
    always_ff @(posedge clk)
    begin
        if (pass_run_reg)
            rd_data_reg <= store_mem[rd_idx_reg[AW-1:0]];
    end

    // Track box corners; the first vertex of a mesh loads them
    always_ff @(posedge clk)
    begin
        for (int a = 0; a < NA; a++)
        begin
            if (cmd.store && !full)
            begin
                if (count_reg == '0 || pos[a] < min_reg[a])
                    min_reg[a] <= pos[a];
                if (count_reg == '0 || pos[a] > max_reg[a])
                    max_reg[a] <= pos[a];
            end
        end
    end

    // Doubled center, stable while no vertex is stored
    always_ff @(posedge clk)
    begin
        for (int a = 0; a < NA; a++)
            c2_reg[a] <= {min_reg[a][CW-1], min_reg[a]} + {max_reg[a][CW-1], max_reg[a]};
    end

    // Fill count and drop flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            drop_reg  <= 1'b0;
        end
        else if (cmd.publish)
        begin
            count_reg <= '0;
            drop_reg  <= 1'b0;
        end
        else if (cmd.store)
        begin
            if (full)
                drop_reg <= 1'b1;
            else
                count_reg <= count_reg + CNTW'(1);
        end
    end

    // Pass address sequencer and pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_run_reg <= 1'b0;
            rd_idx_reg   <= '0;
            s1_vld_reg   <= 1'b0;
            s2_vld_reg   <= 1'b0;
            s3_vld_reg   <= 1'b0;
            s4_vld_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.pass_start)
            begin
                pass_run_reg <= 1'b1;
                rd_idx_reg   <= '0;
            end
            else if (pass_run_reg)
            begin
                rd_idx_reg <= rd_idx_reg + CNTW'(1);
                if (rd_idx_reg == count_reg - CNTW'(1))
                    pass_run_reg <= 1'b0;
            end
            s1_vld_reg <= pass_run_reg;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    // Offsets 2*v - c2, squares, and their sum
    always_ff @(posedge clk)
    begin
        logic signed [OW-1:0]   v_ext;
        logic signed [2*OW-1:0] prod;
        for (int a = 0; a < NA; a++)
        begin
            v_ext       = {{2{rd_data_reg[CW*a+CW-1]}}, rd_data_reg[CW*a +: CW]};
            off_reg[a] <= {v_ext[OW-2:0], 1'b0} - {c2_reg[a][CW], c2_reg[a]};
            prod        = off_reg[a] * off_reg[a];
            sq_reg[a]  <= prod[DW-1:0];
        end
        sum_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
    end

    // Keep the largest distance of the pass
    always_ff @(posedge clk)
    begin
        if (cmd.pass_start)
            best_reg <= '0;
        else if (s4_vld_reg && sum_reg > best_reg)
            best_reg <= sum_reg;
    end

    mbs_isqrt #(
        .DW (DW)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.root_start),
        .radicand (best_reg),
        .busy     (root_busy),
        .root     (root)
    );

    // Result registers
    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            cx_reg     <= c2_reg[0];
            cy_reg     <= c2_reg[1];
            cz_reg     <= c2_reg[2];
            radius_reg <= (CW + 2)'(root);
            ovf_reg    <= drop_reg;
        end
    end

    assign sts.pass_busy = pass_run_reg | s1_vld_reg | s2_vld_reg | s3_vld_reg | s4_vld_reg;
    assign sts.root_busy = root_busy;
    assign center2_x     = cx_reg;
    assign center2_y     = cy_reg;
    assign center2_z     = cz_reg;
    assign radius2       = radius_reg;
    assign overflowed    = ovf_reg;

    a_count_range : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNTW'(MAX_VERTICES))
        else $error("vertex count beyond store depth");

    a_drop_full : assert property (@(posedge clk) disable iff (!rst_n)
        drop_reg |-> full)
        else $error("drop flagged while store not full");

    a_rd_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        pass_run_reg |-> rd_idx_reg < count_reg)
        else $error("pass reads past stored vertices");

endmodule

// ===== rtl/core/mbs_ctrl.sv =====
// Controller of the mesh bounding sphere core: load, distance pass, square
// root and result handoff. Uses mbs_pkg for the command and status types.
`timescale 1ns / 1ps

module mbs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              last_vertex,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output mbs_pkg::mbs_cmd_t cmd,
    input  mbs_pkg::mbs_sts_t sts
);

    typedef enum logic [3:0] {
        ST_LOAD = 4'b0001,
        ST_PASS = 4'b0010,
        ST_ROOT = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // Sequence one mesh through its phases
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_valid)
                begin
                    cmd.store = 1'b1;
                    if (last_vertex)
                    begin
                        cmd.pass_start = 1'b1;
                        state_next     = ST_PASS;
                    end
                end
            end
            ST_PASS:
            begin
                if (!sts.pass_busy)
                begin
                    cmd.root_start = 1'b1;
                    state_next     = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (!sts.root_busy)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Hand off once the output register frees up
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_LOAD);
    assign out_valid = out_valid_reg;

    a_pass_entry : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && last_vertex) |=> (state_reg == ST_PASS))
        else $error("last vertex did not start the distance pass");

    a_root_after_pass : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROOT) |-> !sts.pass_busy)
        else $error("square root started before pass drained");

    a_publish_valid : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |=> out_valid_reg)
        else $error("published result not presented");

endmodule
